### hdl/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES-256 CBC package
// Shared types, constants and byte-, word- and state-level functions of the AES-256 CBC engine.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned RoundCount = 14;
  localparam int unsigned KeyWords   = 8;
  localparam int unsigned CfgIdxW    = 3;

  localparam logic [CfgIdxW-1:0] RegKey0  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKey1  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKey2  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKey3  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegIvHi  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegIvLo  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegDir   = 3'd6;

  localparam logic [7:0] PolyLow = 8'h1b;
  localparam logic [7:0] PadFull = 8'h10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_INIT,
    ST_ROUND,
    ST_OUT
  } state_e;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[x];
  endfunction

  function automatic logic [7:0] sbox_rev(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[x];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? PolyLow : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // state byte i at bits [127-8i -: 8], column c = i/4, row r = i%4
  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] o;
    for (int i = 0; i < 16; i++) b[i] = sbox(s[127-8*i -: 8]);
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) t[c*4+r] = b[((c+r)%4)*4+r];
    for (int c = 0; c < 4; c++) begin
      a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
      if (!last) begin
        t[c*4]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
        t[c*4+1] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
        t[c*4+2] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
        t[c*4+3] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
      end
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
    return o;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a[r]  = s[127-8*(c*4+r) -: 8];
        x2[r] = xt(a[r]);
        x4[r] = xt(x2[r]);
        x8[r] = xt(x4[r]);
      end
      for (int r = 0; r < 4; r++) begin
        o[127-8*(c*4+r) -: 8] =
          (x8[r] ^ x4[r] ^ x2[r]) ^
          (x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4]) ^
          (x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4]) ^
          (x8[(r+3)%4] ^ a[(r+3)%4]);
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
    logic [7:0] b [16];
    logic [127:0] o;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        o[127-8*(c*4+r) -: 8] = sbox_rev(b[((c+4-r)%4)*4+r]);
    return o;
  endfunction

endpackage

### hdl/aes_key_mem.sv
// ----------------------------------------------------------------------------
// AES round key memory
// Round key schedule store: one 128-bit row per round key, written one 32-bit
// word at a time; one write and one registered 128-bit read per cycle.
// ----------------------------------------------------------------------------
module aes_key_mem #(
  parameter int unsigned ROUND_COUNT = aes_pkg::RoundCount
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [$clog2(4*(ROUND_COUNT+1))-1:0] waddr_i,
  input  logic [31:0]                          wdata_i,
  input  logic [$clog2(ROUND_COUNT+1)-1:0]     raddr_i,
  output logic [127:0]                         rdata_o
);
  localparam int unsigned Rows = ROUND_COUNT + 1;

  logic [127:0] mem [Rows];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i[$bits(waddr_i)-1:2]][127-32*waddr_i[1:0] -: 32] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

### hdl/aes256_cbc_cipher.sv
// ----------------------------------------------------------------------------
// AES-256 CBC cipher
// Iterative AES-256 engine in CBC mode with PKCS#7 padding.
// ----------------------------------------------------------------------------
// A block's result shows after its input transfer, an initial key add (its
// round key row is read at the transfer) and 14 rounds, one per cycle, each
// fed from the round key memory. The result is held until transferred and the
// next block is taken in the cycle after that. The first block after a key
// write first runs the key expansion, one schedule word per cycle, then goes
// back to idle to read its first round key again. A full final block in
// encrypt mode runs the cipher a second time on a padding block after the
// first result transfer and gives two results.
module aes256_cbc_cipher #(
  parameter int unsigned ROUND_COUNT = aes_pkg::RoundCount
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [63:0]  block_upper_i,
  input  logic [63:0]  block_lower_i,
  input  logic [4:0]   byte_count_i,
  input  logic         final_block_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [63:0]  out_upper_o,
  output logic [63:0]  out_lower_o,
  output logic [4:0]   valid_bytes_o,
  output logic         last_out_o
);
  localparam int unsigned SchedWords = 4 * (ROUND_COUNT + 1);
  localparam int unsigned WordW = $clog2(SchedWords);
  localparam int unsigned RowW = $clog2(ROUND_COUNT + 1);
  localparam int unsigned KW = aes_pkg::KeyWords;

  aes_pkg::state_e state_q, state_d;

  logic [255:0] key_q;
  logic [127:0] iv_q, chain_q, st_q, blk_q;
  logic         dir_q, keys_ready_q, started_q;
  logic         fin_q, extra_q;
  logic [WordW-1:0] widx_q;
  logic [RowW-1:0]  round_q;
  logic [255:0] win_q;   // last eight schedule words
  logic [7:0]   rc_q;
  // pending item held in blk_q; expansion returns to idle then replays
  logic         pend_q;

  logic         kwe;
  logic [31:0]  kword;
  logic [RowW-1:0] raddr;
  logic [127:0] rk;

  aes_key_mem #(.ROUND_COUNT(ROUND_COUNT)) u_mem (
    .clk_i   (clk_i),
    .we_i    (kwe),
    .waddr_i (widx_q),
    .wdata_i (kword),
    .raddr_i (raddr),
    .rdata_o (rk)
  );

  logic [31:0] tprev, tmod;
  always_comb begin
    tprev = win_q[31:0];
    tmod = tprev;
    if (widx_q[2:0] == 3'd0) begin
      tmod = aes_pkg::sub_word({tprev[23:0], tprev[31:24]}) ^ {rc_q, 24'h0};
    end else if (widx_q[2:0] == 3'd4) begin
      tmod = aes_pkg::sub_word(tprev);
    end
    kword = (widx_q < WordW'(KW)) ? key_q[255-32*widx_q[2:0] -: 32] : win_q[255:224] ^ tmod;
  end
  assign kwe = (state_q == aes_pkg::ST_EXPAND);

  logic accept;
  assign in_ready_o  = (state_q == aes_pkg::ST_IDLE) && !pend_q;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == aes_pkg::ST_OUT);

  // decrypt reads rows from the top down
  logic [RowW-1:0] row_next;
  always_comb begin
    if (state_q == aes_pkg::ST_ROUND || state_q == aes_pkg::ST_INIT) begin
      row_next = dir_q ? round_q - RowW'(1) : round_q + RowW'(1);
    end else begin
      row_next = dir_q ? RowW'(ROUND_COUNT) : '0;
    end
    raddr = row_next;
  end

  logic last_rnd;
  assign last_rnd = dir_q ? (round_q == '0) : (round_q == RowW'(ROUND_COUNT));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      aes_pkg::ST_IDLE: begin
        if (pend_q) state_d = aes_pkg::ST_INIT;
        else if (accept) state_d = keys_ready_q ? aes_pkg::ST_INIT : aes_pkg::ST_EXPAND;
      end
      aes_pkg::ST_EXPAND: if (widx_q == WordW'(SchedWords - 1)) state_d = aes_pkg::ST_IDLE;
      aes_pkg::ST_INIT:   state_d = aes_pkg::ST_ROUND;
      aes_pkg::ST_ROUND:  if (last_rnd) state_d = aes_pkg::ST_OUT;
      aes_pkg::ST_OUT: begin
        if (out_ready_i) state_d = extra_q ? aes_pkg::ST_INIT : aes_pkg::ST_IDLE;
      end
      default: state_d = aes_pkg::ST_IDLE;
    endcase
  end

  logic [127:0] in_blk, pad_blk, cur_chain, dec_res, round_in, round_out;
  logic [4:0]   n_sat;
  always_comb begin
    in_blk = {block_upper_i, block_lower_i};
    n_sat = (byte_count_i > 5'd16) ? 5'd16 : byte_count_i;
    pad_blk = in_blk;
    for (int i = 0; i < 16; i++) begin
      if (5'(i) >= n_sat) pad_blk[127-8*i -: 8] = 8'(5'd16 - n_sat);
    end
    cur_chain = started_q ? chain_q : iv_q;
    round_in = st_q;
    if (dir_q) begin
      round_out = aes_pkg::inv_sub_shift(st_q) ^ rk;
      if (!last_rnd) round_out = aes_pkg::inv_mix(round_out);
    end else begin
      round_out = aes_pkg::enc_round(round_in, last_rnd) ^ rk;
    end
    dec_res = round_out ^ chain_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aes_pkg::ST_IDLE;
      key_q <= '0; iv_q <= '0; dir_q <= 1'b0;
      keys_ready_q <= 1'b0; started_q <= 1'b0; chain_q <= '0;
      widx_q <= '0; round_q <= '0; extra_q <= 1'b0;
      pend_q <= 1'b0; fin_q <= 1'b0; rc_q <= '0; win_q <= '0;
      blk_q <= '0; st_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          aes_pkg::RegKey0: begin key_q[255:192] <= cfg_data_i; keys_ready_q <= 1'b0; end
          aes_pkg::RegKey1: begin key_q[191:128] <= cfg_data_i; keys_ready_q <= 1'b0; end
          aes_pkg::RegKey2: begin key_q[127:64]  <= cfg_data_i; keys_ready_q <= 1'b0; end
          aes_pkg::RegKey3: begin key_q[63:0]    <= cfg_data_i; keys_ready_q <= 1'b0; end
          aes_pkg::RegIvHi: iv_q[127:64] <= cfg_data_i;
          aes_pkg::RegIvLo: iv_q[63:0]   <= cfg_data_i;
          aes_pkg::RegDir:  dir_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      unique case (state_q)
        aes_pkg::ST_IDLE: begin
          if (accept) begin
            widx_q <= '0;
            rc_q <= 8'h01;
            round_q <= dir_q ? RowW'(ROUND_COUNT) : '0;
            chain_q <= cur_chain;
            started_q <= !final_block_i;
            fin_q <= final_block_i;
            extra_q <= !dir_q && final_block_i && (n_sat == 5'd16);
            blk_q <= (!dir_q && final_block_i) ? pad_blk : in_blk;
            st_q <= (!dir_q && final_block_i) ? pad_blk : in_blk;
          end else if (pend_q) begin
            pend_q <= 1'b0;
          end
        end
        aes_pkg::ST_EXPAND: begin
          win_q <= {win_q[223:0], kword};
          widx_q <= widx_q + WordW'(1);
          if (widx_q[2:0] == 3'd0 && widx_q >= WordW'(KW)) rc_q <= aes_pkg::xt(rc_q);
          if (widx_q == WordW'(SchedWords - 1)) begin
            keys_ready_q <= 1'b1;
            pend_q <= 1'b1;
          end
        end
        aes_pkg::ST_INIT: begin
          // row was read last cycle: add initial key, step round counter
          st_q <= (dir_q ? blk_q : blk_q ^ chain_q) ^ rk;
          round_q <= row_next;
        end
        aes_pkg::ST_ROUND: begin
          st_q <= (last_rnd && dir_q) ? dec_res : round_out;
          round_q <= row_next;
          if (last_rnd) begin
            if (dir_q) begin
              chain_q <= blk_q;
            end else begin
              chain_q <= round_out;
            end
          end
        end
        aes_pkg::ST_OUT: begin
          if (out_ready_i && extra_q) begin
            extra_q <= 1'b0;
            blk_q <= {16{aes_pkg::PadFull}};
            round_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // strip padding on the final decrypt block
  logic [4:0] vb;
  always_comb begin
    vb = 5'd16;
    if (dir_q && fin_q && st_q[7:0] >= 8'd1 && st_q[7:0] <= 8'd16) begin
      vb = 5'(8'd16 - st_q[7:0]);
    end
  end

  assign out_upper_o   = st_q[127:64];
  assign out_lower_o   = st_q[63:0];
  assign valid_bytes_o = vb;
  assign last_out_o    = fin_q && !extra_q;
endmodule

### hdl/aes256_cbc_cipher_chk.sv
// ----------------------------------------------------------------------------
// AES-256 CBC port checker
// Concurrent checks on the handshake ports and valid byte count of the AES-256 CBC cipher.
// ----------------------------------------------------------------------------
module aes256_cbc_cipher_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] out_upper_o,
  input logic [4:0]  valid_bytes_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_upper_o))
    else $error("result dropped while stalled");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while result pending");
  a_vb_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> valid_bytes_o <= 5'd16)
    else $error("valid byte count out of range");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready after transfer");
endmodule

bind aes256_cbc_cipher aes256_cbc_cipher_chk u_chk (.*);
